// ===== hdl/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types, codes and helpers for the priority interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

    // transaction kinds
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_RAISE = 2'd2,
        CMD_ACK   = 2'd3
    } t_cmd;

    // register port select
    localparam logic PORT_COMMAND = 1'b0;
    localparam logic PORT_DATA    = 1'b1;

    // initialization sequence position
    typedef enum logic [1:0] {
        INIT_IDLE = 2'd0,
        INIT_ICW2 = 2'd1,
        INIT_ICW3 = 2'd2,
        INIT_ICW4 = 2'd3
    } t_init_step;

    // command byte bit positions
    localparam int unsigned CW_ICW1_BIT     = 4;
    localparam int unsigned CW_OCW3_BIT     = 3;
    localparam int unsigned CW_EOI_BIT      = 5;
    localparam int unsigned CW_SPECIFIC_BIT = 6;
    localparam int unsigned CW_RR_BIT       = 1;
    localparam int unsigned CW_RIS_BIT      = 0;
    localparam int unsigned CW_IC4_BIT      = 0;
    localparam int unsigned MODE_AEOI_BIT   = 1;

    localparam logic [7:0] MASK_RESET = 8'hff;

    // index of the lowest set bit of a one-hot byte
    function automatic logic [2:0] f_encode(input logic [7:0] onehot);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (onehot[i]) begin
                idx = idx | 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hdl/priority_interrupt_controller_unit.sv =====
// ----------------------------------------------------------------------------
// priority_interrupt_controller_unit
// Single 8259-style interrupt controller with fixed priority, line 0 highest.
// ----------------------------------------------------------------------------
// Every input transaction (bus write, bus read, request raise or interrupt
// acknowledge) is accepted and updates the controller registers at the
// accepting edge; its result appears in the output register on the next
// cycle. One transaction per cycle is sustained: the output register is only
// held when it is full and the consumer stalls, so input stall follows output
// stall. The critical path is the 8-bit priority resolve on the acknowledge.
module priority_interrupt_controller_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  pic_pkg::t_cmd       i_command,
    input  logic                i_port_select,
    input  logic [7:0]          i_write_data,
    input  logic [2:0]          i_irq_line,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_read_data,
    output logic [7:0]          o_vector,
    output logic                o_vector_valid
);
    import pic_pkg::*;

    // controller registers
    t_init_step r_init_step, n_init_step;
    logic       r_expect_mode, n_expect_mode;
    logic [4:0] r_vector_base, n_vector_base;
    logic [7:0] r_cascade, n_cascade;
    logic [7:0] r_mode, n_mode;
    logic [7:0] r_mask, n_mask;
    logic [7:0] r_request, n_request;
    logic [7:0] r_service, n_service;
    logic       r_read_isr, n_read_isr;

    // result register
    logic       r_out_valid;
    logic [7:0] r_read_data, n_read_data;
    logic [7:0] r_vector, n_vector;
    logic       r_vector_valid, n_vector_valid;

    logic       w_accept;
    logic [7:0] w_pending;
    logic [7:0] w_ack_onehot;
    logic [7:0] w_upto;
    logic       w_ack_hit;
    logic [2:0] w_ack_line;

    // handshake
    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    // priority resolve for acknowledge
    assign w_pending    = r_request & ~r_mask;
    assign w_ack_onehot = w_pending & (~w_pending + 8'd1);
    assign w_upto       = w_ack_onehot | (w_ack_onehot - 8'd1);
    assign w_ack_hit    = (w_ack_onehot != 8'd0) && ((r_service & w_upto) == 8'd0);
    assign w_ack_line   = f_encode(w_ack_onehot);

    // next state and result for one transaction
    always_comb begin
        n_init_step    = r_init_step;
        n_expect_mode  = r_expect_mode;
        n_vector_base  = r_vector_base;
        n_cascade      = r_cascade;
        n_mode         = r_mode;
        n_mask         = r_mask;
        n_request      = r_request;
        n_service      = r_service;
        n_read_isr     = r_read_isr;
        n_read_data    = 8'd0;
        n_vector       = 8'd0;
        n_vector_valid = 1'b0;

        unique case (i_command)
            CMD_WRITE: begin
                if (i_port_select == PORT_DATA) begin
                    unique case (r_init_step)
                        INIT_ICW2: begin
                            n_vector_base = i_write_data[7:3];
                            n_init_step   = INIT_ICW3;
                        end
                        INIT_ICW3: begin
                            n_cascade   = i_write_data;
                            n_init_step = r_expect_mode ? INIT_ICW4 : INIT_IDLE;
                        end
                        INIT_ICW4: begin
                            n_mode      = i_write_data;
                            n_init_step = INIT_IDLE;
                        end
                        default: begin
                            n_mask = i_write_data;
                        end
                    endcase
                end else if (i_write_data[CW_ICW1_BIT]) begin
                    // start of initialization
                    n_init_step   = INIT_ICW2;
                    n_expect_mode = i_write_data[CW_IC4_BIT];
                    n_mask        = 8'd0;
                    n_read_isr    = 1'b0;
                end else if (i_write_data[CW_OCW3_BIT]) begin
                    if (i_write_data[CW_RR_BIT]) begin
                        n_read_isr = i_write_data[CW_RIS_BIT];
                    end
                end else if (i_write_data[CW_EOI_BIT]) begin
                    if (i_write_data[CW_SPECIFIC_BIT]) begin
                        n_service = r_service & ~(8'd1 << i_write_data[2:0]);
                    end else begin
                        // clear lowest in-service bit
                        n_service = r_service & (r_service - 8'd1);
                    end
                end
            end
            CMD_READ: begin
                if (i_port_select == PORT_DATA) begin
                    n_read_data = r_mask;
                end else begin
                    n_read_data = r_read_isr ? r_service : r_request;
                end
            end
            CMD_RAISE: begin
                n_request = r_request | (8'd1 << i_irq_line);
            end
            default: begin
                if (w_ack_hit) begin
                    n_request = r_request & ~w_ack_onehot;
                    if (!r_mode[MODE_AEOI_BIT]) begin
                        n_service = r_service | w_ack_onehot;
                    end
                    n_vector       = {r_vector_base, w_ack_line};
                    n_vector_valid = 1'b1;
                end
            end
        endcase
    end

    // controller state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_step   <= INIT_IDLE;
            r_expect_mode <= 1'b0;
            r_vector_base <= 5'd0;
            r_cascade     <= 8'd0;
            r_mode        <= 8'd0;
            r_mask        <= MASK_RESET;
            r_request     <= 8'd0;
            r_service     <= 8'd0;
            r_read_isr    <= 1'b0;
        end else if (w_accept) begin
            r_init_step   <= n_init_step;
            r_expect_mode <= n_expect_mode;
            r_vector_base <= n_vector_base;
            r_cascade     <= n_cascade;
            r_mode        <= n_mode;
            r_mask        <= n_mask;
            r_request     <= n_request;
            r_service     <= n_service;
            r_read_isr    <= n_read_isr;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_data    <= n_read_data;
            r_vector       <= n_vector;
            r_vector_valid <= n_vector_valid;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_read_data    = r_read_data;
    assign o_vector       = r_vector;
    assign o_vector_valid = r_vector_valid;

    // a served acknowledge never carries read data
    a_vec_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_vector_valid) |-> (r_read_data == 8'd0))
        else $error("read data present alongside a vector");

    // only reads return data
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command != CMD_READ) |=> (o_read_data == 8'd0))
        else $error("read data on a non-read transaction");

    // initialization start unmasks all lines
    a_icw1_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command == CMD_WRITE && i_port_select == PORT_COMMAND
         && i_write_data[CW_ICW1_BIT])
        |=> (r_mask == 8'd0 && r_init_step == INIT_ICW2 && !r_read_isr))
        else $error("initialization start did not take effect");

    // mode word only expected when requested
    a_icw4_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_init_step == INIT_ICW4) |-> r_expect_mode)
        else $error("mode word step without request");

    // served request is cleared
    a_ack_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command == CMD_ACK && w_ack_hit)
        |=> ((r_request & $past(w_ack_onehot)) == 8'd0) && o_vector_valid)
        else $error("served request still pending");

endmodule

// ===== verif/pic_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pic_checker
// Watches both channels of the interrupt controller, keeps its own copy of
// the controller registers, predicts each result and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module pic_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  pic_pkg::t_cmd i_command,
    input  logic          i_port_select,
    input  logic [7:0]    i_write_data,
    input  logic [2:0]    i_irq_line,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  logic [7:0]    i_read_data,
    input  logic [7:0]    i_vector,
    input  logic          i_vector_valid,
    output int            o_fail_count,
    output int            o_pending_count
);
    import pic_pkg::*;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] vector;
        logic       vector_valid;
    } t_pic_result;

    localparam int MAX_PRINTED = 100;

    // predicted controller registers
    t_init_step icw_stage;
    logic       need_icw4;
    logic [4:0] vec_base;
    logic [7:0] cascade_byte;
    logic [7:0] mode_byte;
    logic [7:0] imr;
    logic [7:0] irr;
    logic [7:0] isr;
    logic       show_isr;

    t_pic_result expected_results[$];
    int          fail_count    = 0;
    int          pending       = 0;
    int          results_count = 0;

    assign o_fail_count    = fail_count;
    assign o_pending_count = pending;

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTED) begin
            $display("[%0t] mismatch at result %0d: %s", $realtime, results_count, msg);
        end
        fail_count++;
    endtask

    // lowest set bit of a byte, 8 when the byte is zero
    function automatic logic [3:0] lowest_set(input logic [7:0] v);
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                return 4'(i);
            end
        end
        return 4'd8;
    endfunction

    // advance the predicted registers by one transaction and form its result
    task automatic predict_transaction(
        input  t_cmd        cmd,
        input  logic        port,
        input  logic [7:0]  d,
        input  logic [2:0]  line,
        output t_pic_result res
    );
        logic [3:0] n;
        logic [7:0] servable;
        logic [7:0] upto;
        res = '0;
        case (cmd)
            CMD_WRITE: begin
                if (port == PORT_DATA) begin
                    // init words first, then the mask
                    case (icw_stage)
                        INIT_ICW2: begin
                            vec_base  = d[7:3];
                            icw_stage = INIT_ICW3;
                        end
                        INIT_ICW3: begin
                            cascade_byte = d;
                            icw_stage    = need_icw4 ? INIT_ICW4 : INIT_IDLE;
                        end
                        INIT_ICW4: begin
                            mode_byte = d;
                            icw_stage = INIT_IDLE;
                        end
                        default: begin
                            imr = d;
                        end
                    endcase
                end else if (d[CW_ICW1_BIT]) begin
                    icw_stage = INIT_ICW2;
                    need_icw4 = d[CW_IC4_BIT];
                    imr       = 8'h00;
                    show_isr  = 1'b0;
                end else if (d[CW_OCW3_BIT]) begin
                    if (d[CW_RR_BIT]) begin
                        show_isr = d[CW_RIS_BIT];
                    end
                end else if (d[CW_EOI_BIT]) begin
                    if (d[CW_SPECIFIC_BIT]) begin
                        isr[d[2:0]] = 1'b0;
                    end else begin
                        n = lowest_set(isr);
                        if (n < 4'd8) begin
                            isr[n[2:0]] = 1'b0;
                        end
                    end
                end
            end
            CMD_READ: begin
                if (port == PORT_DATA) begin
                    res.read_data = imr;
                end else begin
                    res.read_data = show_isr ? isr : irr;
                end
            end
            CMD_RAISE: begin
                irr[line] = 1'b1;
            end
            default: begin
                // acknowledge: best unmasked request unless blocked by service
                servable = irr & ~imr;
                n        = lowest_set(servable);
                if (n < 4'd8) begin
                    upto = 8'((16'd2 << n) - 16'd1);
                    if ((isr & upto) == 8'h00) begin
                        irr[n[2:0]] = 1'b0;
                        if (!mode_byte[MODE_AEOI_BIT]) begin
                            isr[n[2:0]] = 1'b1;
                        end
                        res.vector       = {vec_base, n[2:0]};
                        res.vector_valid = 1'b1;
                    end
                end
            end
        endcase
    endtask

    // results are compared before the transaction of the same edge is predicted
    always @(posedge i_clk) begin
        t_pic_result want;
        t_pic_result prediction;
        if (!i_rst_n) begin
            icw_stage    = INIT_IDLE;
            need_icw4    = 1'b0;
            vec_base     = '0;
            cascade_byte = '0;
            mode_byte    = '0;
            imr          = MASK_RESET;
            irr          = '0;
            isr          = '0;
            show_isr     = 1'b0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no transaction waiting for it");
                end else begin
                    want = expected_results.pop_front();
                    if (i_read_data !== want.read_data) begin
                        report_mismatch($sformatf("read_data expected %02h got %02h",
                                                  want.read_data, i_read_data));
                    end
                    if (i_vector !== want.vector) begin
                        report_mismatch($sformatf("vector expected %02h got %02h",
                                                  want.vector, i_vector));
                    end
                    if (i_vector_valid !== want.vector_valid) begin
                        report_mismatch($sformatf("vector_valid expected %0b got %0b",
                                                  want.vector_valid, i_vector_valid));
                    end
                end
                results_count++;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_transaction(i_command, i_port_select, i_write_data, i_irq_line,
                                    prediction);
                expected_results.push_back(prediction);
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== verif/priority_interrupt_controller_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_interrupt_controller_unit_tb
// Drives bus writes, bus reads, request raises and acknowledges into the
// interrupt controller: a directed opening over init words, end of interrupt
// forms and register reads, then random well-formed traffic with noise, with
// random gaps and back pressure. pic_checker does all the comparing.
// ----------------------------------------------------------------------------
module priority_interrupt_controller_unit_tb;
    import pic_pkg::*;

    localparam int NUM_RANDOM     = 1800;
    localparam int PHASE_LEN      = 300;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int TAIL_CYCLES    = 4;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_cmd       i_command;
    logic       i_port_select;
    logic [7:0] i_write_data;
    logic [2:0] i_irq_line;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_read_data;
    logic [7:0] o_vector;
    logic       o_vector_valid;

    int fail_count;
    int pending_count;
    int items_sent   = 0;
    int results_seen = 0;
    int vectors_seen = 0;
    int init_seqs    = 0;
    int idle_cycles  = 0;
    bit idle_en      = 1'b1;

    priority_interrupt_controller_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_port_select  (i_port_select),
        .i_write_data   (i_write_data),
        .i_irq_line     (i_irq_line),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data),
        .o_vector       (o_vector),
        .o_vector_valid (o_vector_valid)
    );

    pic_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_command       (i_command),
        .i_port_select   (i_port_select),
        .i_write_data    (i_write_data),
        .i_irq_line      (i_irq_line),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_read_data     (o_read_data),
        .i_vector        (o_vector),
        .i_vector_valid  (o_vector_valid),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // one transaction after a random gap, held until accepted
    task automatic send_item(input t_cmd cmd, input logic port, input logic [7:0] d,
                             input logic [2:0] line);
        int gap;
        gap = idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_port_select <= port;
        i_write_data  <= d;
        i_irq_line    <= line;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // hold off new transactions until every predicted result has come back
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        @(posedge i_clk);
    endtask

    // result side back pressure
    initial begin
        int hold;
        i_stall <= 1'b0;
        forever begin
            hold = idle_en ? $urandom_range(0, 4) : 0;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // activity counters and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (o_vector_valid) begin
                    vectors_seen++;
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int         next_phase;
        int         sel;
        logic [7:0] icw1;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_command     <= CMD_WRITE;
        i_port_select <= PORT_COMMAND;
        i_write_data  <= 8'h00;
        i_irq_line    <= 3'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset values, masked requests, init with interleaved
        // commands, blocking by service, each end of interrupt form, auto eoi
        send_item(CMD_READ,  PORT_DATA,    8'h00, 3'd0);
        send_item(CMD_READ,  PORT_COMMAND, 8'hff, 3'd7);
        send_item(CMD_RAISE, PORT_COMMAND, 8'h00, 3'd7);
        send_item(CMD_RAISE, PORT_DATA,    8'hff, 3'd0);
        send_item(CMD_ACK,   PORT_COMMAND, 8'h00, 3'd0);
        send_item(CMD_WRITE, PORT_COMMAND, 8'h11, 3'd0);
        send_item(CMD_WRITE, PORT_DATA,    8'hff, 3'd0);
        send_item(CMD_WRITE, PORT_COMMAND, 8'h0b, 3'd0);
        send_item(CMD_ACK,   PORT_DATA,    8'h00, 3'd0);
        send_item(CMD_WRITE, PORT_DATA,    8'h04, 3'd0);
        send_item(CMD_WRITE, PORT_DATA,    8'h01, 3'd0);
        send_item(CMD_ACK,   PORT_COMMAND, 8'h00, 3'd0);
        send_item(CMD_READ,  PORT_COMMAND, 8'h00, 3'd0);
        send_item(CMD_WRITE, PORT_COMMAND, 8'ha0, 3'd0);
        send_item(CMD_ACK,   PORT_COMMAND, 8'h00, 3'd0);
        send_item(CMD_WRITE, PORT_COMMAND, 8'h67, 3'd0);
        send_item(CMD_WRITE, PORT_COMMAND, 8'h4c, 3'd0);
        send_item(CMD_WRITE, PORT_COMMAND, 8'h00, 3'd0);
        send_item(CMD_WRITE, PORT_DATA,    8'h55, 3'd0);
        send_item(CMD_READ,  PORT_DATA,    8'h00, 3'd0);
        send_item(CMD_WRITE, PORT_COMMAND, 8'h13, 3'd0);
        send_item(CMD_WRITE, PORT_DATA,    8'h07, 3'd0);
        send_item(CMD_WRITE, PORT_DATA,    8'h00, 3'd0);
        send_item(CMD_WRITE, PORT_DATA,    8'h02, 3'd0);
        send_item(CMD_RAISE, PORT_COMMAND, 8'h00, 3'd3);
        send_item(CMD_ACK,   PORT_COMMAND, 8'h00, 3'd0);
        wait_for_results();

        // random traffic in phases, alternating idling on and off
        next_phase = items_sent + PHASE_LEN;
        while (items_sent < NUM_RANDOM) begin
            if (items_sent >= next_phase) begin
                wait_for_results();
                idle_en    = ~idle_en;
                next_phase = items_sent + PHASE_LEN;
            end
            sel = $urandom_range(0, 99);
            if (sel < 6) begin
                // init sequence, sometimes with a request or ack in between
                icw1 = 8'($urandom) | 8'h10;
                init_seqs++;
                send_item(CMD_WRITE, PORT_COMMAND, icw1, 3'($urandom));
                send_item(CMD_WRITE, PORT_DATA, 8'($urandom), 3'($urandom));
                if ($urandom_range(0, 3) == 0) begin
                    send_item(t_cmd'($urandom_range(2, 3)), 1'($urandom), 8'($urandom),
                              3'($urandom));
                end
                send_item(CMD_WRITE, PORT_DATA, 8'($urandom), 3'($urandom));
                if (icw1[CW_IC4_BIT]) begin
                    send_item(CMD_WRITE, PORT_DATA, 8'($urandom), 3'($urandom));
                end
            end else if (sel < 12) begin
                // mask write, mostly sparse so requests get through
                send_item(CMD_WRITE, PORT_DATA,
                          ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                      : 8'($urandom & $urandom & $urandom),
                          3'($urandom));
            end else if (sel < 40) begin
                send_item(CMD_RAISE, 1'($urandom), 8'($urandom), 3'($urandom));
            end else if (sel < 65) begin
                send_item(CMD_ACK, 1'($urandom), 8'($urandom), 3'($urandom));
            end else if (sel < 75) begin
                // end of interrupt, specific or not, rotating or not
                send_item(CMD_WRITE, PORT_COMMAND,
                          {1'($urandom), 1'($urandom), 1'b1, 2'b00, 3'($urandom)},
                          3'($urandom));
            end else if (sel < 82) begin
                // read register select, mostly the plain forms
                send_item(CMD_WRITE, PORT_COMMAND,
                          ($urandom_range(0, 1) == 0)
                              ? {7'b0000101, 1'($urandom)}
                              : {3'($urandom), 1'b0, 1'b1, 3'($urandom)},
                          3'($urandom));
            end else if (sel < 95) begin
                send_item(CMD_READ, 1'($urandom), 8'($urandom), 3'($urandom));
            end else begin
                send_item(t_cmd'($urandom_range(0, 3)), 1'($urandom), 8'($urandom),
                          3'($urandom));
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d transactions with %0d init sequences", items_sent,
                 init_seqs);
        $display("checked %0d results, %0d of them served interrupt vectors",
                 results_seen, vectors_seen);
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pic_pkg.sv
hdl/priority_interrupt_controller_unit.sv
verif/pic_checker.sv
verif/priority_interrupt_controller_unit_tb.sv
